>>> rtl/thd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thd_pkg: shared types and constants for the THD-from-spectrum block
// Widths of bins, energies and the payload structs of both channels.
// ----------------------------------------------------------------------------
package thd_pkg;
   localparam int HALF_BINS = 512;
   localparam int IDX_W     = $clog2(HALF_BINS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int EN_W      = 34;
   localparam int SUM_W     = 44;
   localparam logic [IDX_W-1:0] START_RESET = IDX_W'(25);

   typedef struct packed {
      logic signed [15:0] bin_real;
      logic signed [15:0] bin_imag;
      logic               last_bin;
   } req_type;

   typedef struct packed {
      logic [8:0]  peak_bin;
      logic [17:0] fundamental_rms;
      logic [23:0] harmonic_rms;
      logic [15:0] thd_percent_q8;
      logic        zero_fundamental;
   } rsp_type;

   // one queued bin after classification
   typedef struct packed {
      logic [EN_W-1:0]  energy;
      logic [IDX_W-1:0] idx;
      logic             store;
      logic             last;
   } bin_type;
endpackage

>>> rtl/thd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thd_front: bin intake
// Computes bin energy, counts bins and flags overflow bins and frame end.
// ----------------------------------------------------------------------------
module thd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  thd_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_ready,
   output thd_pkg::bin_type q_data
);
   import thd_pkg::*;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             vld_ff;
   bin_type          bin_ff;
   logic [31:0]      sq_re, sq_im;
   logic [32:0]      sum;
   logic             take;

   assign req_ready = !vld_ff || q_ready;
   assign take      = req_valid && req_ready;
   assign q_valid   = vld_ff;
   assign q_data    = bin_ff;

   // square the parts
   assign sq_re = 32'($signed(req_data.bin_real) * $signed(req_data.bin_real));
   assign sq_im = 32'($signed(req_data.bin_imag) * $signed(req_data.bin_imag));
   assign sum   = {1'b0, sq_re} + {1'b0, sq_im};

   // advance bin count, clear at frame end
   always_comb begin
      cnt_in = cnt_ff;
      if (take) begin
         if (req_data.last_bin) cnt_in = '0;
         else if (cnt_ff < CNT_W'(HALF_BINS)) cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (take) vld_ff <= 1'b1;
         else if (q_ready) vld_ff <= 1'b0;
      end
   end

   // sum peaks at 2^31, so bit 32 is always clear and the shifted value fits
   always_ff @(posedge clock) begin
      if (take) begin
         bin_ff.energy <= (cnt_ff == '0) ? EN_W'(sum) : {sum[31:0], 2'b00};
         bin_ff.idx    <= cnt_ff[IDX_W-1:0];
         bin_ff.store  <= cnt_ff < CNT_W'(HALF_BINS);
         bin_ff.last   <= req_data.last_bin;
      end
   end
endmodule

>>> rtl/thd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thd_sqrt: iterative floor square root
// One result bit per cycle, restoring method over a 44-bit radicand.
// ----------------------------------------------------------------------------
module thd_sqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [thd_pkg::SUM_W-1:0] value,
   output logic                     done,
   output logic [thd_pkg::SUM_W/2-1:0] root
);
   import thd_pkg::*;
   localparam int RW = SUM_W / 2;

   logic [SUM_W-1:0] rad_ff;
   logic [RW+1:0]    rem_ff;
   logic [RW-1:0]    root_ff;
   logic [5:0]       step_ff;
   logic             busy_ff;
   logic [RW+1:0]    trial, rem_sh;

   assign rem_sh = {rem_ff[RW-1:0], rad_ff[SUM_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign root   = root_ff;

   // take two radicand bits each step
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            rad_ff  <= value;
            rem_ff  <= '0;
            root_ff <= '0;
            step_ff <= 6'(RW);
         end else if (busy_ff) begin
            rad_ff <= {rad_ff[SUM_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[RW-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[RW-2:0], 1'b0};
            end
            step_ff <= step_ff - 1'b1;
            if (step_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
   end
endmodule

>>> rtl/thd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thd_back: energy store, peak search and end-of-frame evaluation
// Walks the harmonics through the store, takes roots and divides.
// ----------------------------------------------------------------------------
module thd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [thd_pkg::IDX_W-1:0] start_bin,
   input  logic                    q_valid,
   output logic                    q_ready,
   input  thd_pkg::bin_type        q_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output thd_pkg::rsp_type        rsp_data
);
   import thd_pkg::*;

   localparam logic [3:0] S_LOAD = 4'd0, S_RD = 4'd1, S_WAIT = 4'd2, S_ACC = 4'd3,
      S_NEXT = 4'd4, S_SQF = 4'd5, S_SQFW = 4'd6, S_SQH = 4'd7, S_SQHW = 4'd8,
      S_DIV = 4'd9, S_OUT = 4'd10;

   logic [EN_W-1:0]  mem [HALF_BINS];
   logic [EN_W-1:0]  rd_ff;
   logic [3:0]       st_ff;
   logic [EN_W-1:0]  pk_e_ff;
   logic [IDX_W-1:0] pk_i_ff;
   logic [CNT_W-1:0] len_ff, ctr_ff, k_ff;
   logic [1:0]       off_ff;
   logic [CNT_W:0]   addr;
   logic             in_rng;
   logic [SUM_W-1:0] fund_ff, harm_ff, acc_ff;
   logic             harm_ph_ff;
   logic             sq_start;
   logic [SUM_W-1:0] sq_val;
   logic             sq_done;
   logic [SUM_W/2-1:0] sq_root;
   logic [17:0]      frms_ff;
   logic [23:0]      hrms_ff;
   logic [39:0]      num_ff;
   logic [40:0]      rem_ff;
   logic [5:0]       dstep_ff;
   logic [40:0]      rem_sh;
   logic             take;

   assign q_ready = (st_ff == S_LOAD);
   assign take    = q_valid && q_ready;

   // neighbor address: k-1, k, k+1
   assign addr   = {1'b0, k_ff} + (CNT_W+1)'(off_ff) - 1'b1;
   assign in_rng = !(k_ff == '0 && off_ff == 2'd0) && addr < {1'b0, len_ff};

   // store energies
   always_ff @(posedge clock) begin
      if (take && q_data.store) mem[q_data.idx] <= q_data.energy;
      rd_ff <= mem[addr[IDX_W-1:0]];
   end

   assign sq_start = (st_ff == S_SQF) || (st_ff == S_SQH);
   assign sq_val   = (st_ff == S_SQF) ? fund_ff : harm_ff;

   thd_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (sq_val),
      .done  (sq_done),
      .root  (sq_root)
   );

   assign rem_sh = {rem_ff[39:0], num_ff[39]};

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_LOAD;
         ctr_ff  <= '0;
         pk_e_ff <= '0;
         pk_i_ff <= '0;
      end else begin
         unique case (st_ff)
            S_LOAD: if (take) begin
               // track peak, first maximum wins
               if (q_data.store) begin
                  ctr_ff <= ctr_ff + 1'b1;
                  if (q_data.idx == start_bin ||
                      (q_data.idx > start_bin && q_data.energy > pk_e_ff)) begin
                     pk_e_ff <= q_data.energy;
                     pk_i_ff <= q_data.idx;
                  end
               end
               if (q_data.last) begin
                  len_ff  <= ctr_ff + CNT_W'(q_data.store);
                  if (q_data.store && (q_data.idx == start_bin ||
                      (q_data.idx > start_bin && q_data.energy > pk_e_ff)))
                     k_ff <= CNT_W'(q_data.idx);
                  else
                     k_ff <= CNT_W'(pk_i_ff);
                  off_ff     <= 2'd0;
                  acc_ff     <= '0;
                  harm_ph_ff <= 1'b0;
                  harm_ff    <= '0;
                  st_ff      <= S_RD;
               end
            end
            S_RD:   st_ff <= S_WAIT;
            S_WAIT: st_ff <= S_ACC;
            S_ACC: begin
               if (in_rng) acc_ff <= acc_ff + SUM_W'(rd_ff);
               if (off_ff == 2'd2) st_ff <= S_NEXT;
               else begin
                  off_ff <= off_ff + 1'b1;
                  st_ff  <= S_RD;
               end
            end
            S_NEXT: begin
               // step to next harmonic
               off_ff <= 2'd0;
               acc_ff <= '0;
               if (!harm_ph_ff) fund_ff <= acc_ff;
               else harm_ff <= harm_ff + acc_ff;
               harm_ph_ff <= 1'b1;
               if (!harm_ph_ff) begin
                  if (pk_i_ff != '0 && {1'b0, k_ff} + {1'b0, k_ff} <
                      {1'b0, len_ff}) begin
                     k_ff  <= k_ff + k_ff;
                     st_ff <= S_RD;
                  end else st_ff <= S_SQF;
               end else if ({1'b0, k_ff} + (CNT_W+1)'(pk_i_ff) < {1'b0, len_ff}) begin
                  k_ff  <= k_ff + CNT_W'(pk_i_ff);
                  st_ff <= S_RD;
               end else st_ff <= S_SQF;
            end
            S_SQF:  st_ff <= S_SQFW;
            S_SQFW: if (sq_done) begin
               frms_ff <= sq_root[17:0];
               st_ff   <= S_SQH;
            end
            S_SQH:  st_ff <= S_SQHW;
            S_SQHW: if (sq_done) begin
               hrms_ff  <= sq_root[23:0];
               num_ff   <= 40'(sq_root[23:0]) * 40'd25600;
               rem_ff   <= '0;
               dstep_ff <= 6'd40;
               st_ff    <= S_DIV;
            end
            S_DIV: begin
               // restoring division, one quotient bit a cycle
               if (rem_sh >= {23'd0, frms_ff}) begin
                  rem_ff <= rem_sh - {23'd0, frms_ff};
                  num_ff <= {num_ff[38:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  num_ff <= {num_ff[38:0], 1'b0};
               end
               dstep_ff <= dstep_ff - 1'b1;
               if (dstep_ff == 6'd1) st_ff <= S_OUT;
            end
            S_OUT: if (rsp_ready) begin
               st_ff   <= S_LOAD;
               ctr_ff  <= '0;
               pk_e_ff <= '0;
               pk_i_ff <= '0;
            end
            default: st_ff <= S_LOAD;
         endcase
      end
   end

   // saturate on a zero root or a quotient above 16 bits
   assign rsp_valid = (st_ff == S_OUT);
   always_comb begin
      rsp_data.peak_bin         = 9'(pk_i_ff);
      rsp_data.fundamental_rms  = frms_ff;
      rsp_data.harmonic_rms     = hrms_ff;
      rsp_data.zero_fundamental = (fund_ff == '0);
      if (frms_ff == '0 || num_ff[39:16] != '0)
         rsp_data.thd_percent_q8 = 16'hFFFF;
      else
         rsp_data.thd_percent_q8 = num_ff[15:0];
   end
endmodule

>>> rtl/thd_from_fft_bins_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thd_from_fft_bins_core: THD measurement from half-spectrum FFT bins
// Stores bin energies, finds the fundamental, sums harmonics and reports
// RMS values and THD percent.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/ready   | thd_pkg::req_type
//  rsp     | out       | rsp_valid/ready   | thd_pkg::rsp_type
//  csr     | in        | csr_write_enable  | search_start_bin
// Bins transfer at one per cycle into the front stage while the back
// loads; the back writes one bin per cycle into the energy memory.
// After the last bin, each three-bin group is read neighbor by neighbor
// (S_RD, S_WAIT, S_ACC for each) and closed by an S_NEXT step, then
// come two square roots and a restoring divide.
// The front stalls while the back is evaluating a frame.
// Reset is synchronous; the energy memory needs no clearing.
module thd_from_fft_bins_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  thd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output thd_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [8:0]       csr_write_data
);
   import thd_pkg::*;

   logic [IDX_W-1:0] start_ff;
   logic             q_valid, q_ready;
   bin_type          q_data;

   // hold start bin register
   always_ff @(posedge clock) begin
      if (reset) start_ff <= START_RESET;
      else if (csr_write_enable) start_ff <= csr_write_data;
   end

   thd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data)
   );

   thd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .start_bin (start_ff),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp dropped while stalled");
   a_zero_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_fundamental |-> rsp_data.thd_percent_q8 == 16'hFFFF)
      else $error("zero fundamental not saturated");
endmodule
